### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define CBP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Property checked on every clock edge, reset included.
`define CBP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CBP_ASSERT(lbl, clk, rstn, prop)
`define CBP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Types, codes and defaults of the compacting block pool.
// ----------------------------------------------------------------------------
package cbp_pkg;

    // Default sizes.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int POOL_BYTES_DEF = 16384;

    // Field widths.
    localparam int KIND_W  = 3;
    localparam int DIM_W   = 8;
    localparam int IDX_W   = 16;
    localparam int OFF_W   = 14;
    localparam int FREE_W  = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM = 1'd1;
    localparam logic [DIM_W-1:0] MIN_DIM_RST = 8'd1;
    localparam logic [DIM_W-1:0] MAX_DIM_RST = 8'd64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_MOVE,
        ST_SWEEP,
        ST_APPEND,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    // A dimension passes when it lies within the configured limits.
    function automatic logic dim_ok(input logic [DIM_W-1:0] d,
                                    input logic [DIM_W-1:0] mn,
                                    input logic [DIM_W-1:0] mx);
        return (d >= mn) && (d <= mx);
    endfunction

endpackage

### hdl/cbp_req_if.sv
// ----------------------------------------------------------------------------
// cbp_req_if / cbp_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface cbp_req_if import cbp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [7:0]        slot;
    logic [DIM_W-1:0]  put_width;
    logic [DIM_W-1:0]  put_height;
    logic [7:0]        pixel_value;
    logic [IDX_W-1:0]  byte_index;

    modport source (output valid, kind, slot, put_width, put_height, pixel_value,
                    byte_index, input ready);
    modport sink (input valid, kind, slot, put_width, put_height, pixel_value,
                  byte_index, output ready);
endinterface

interface cbp_rsp_if import cbp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              ok;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [OFF_W-1:0]  block_offset;
    logic [7:0]        read_byte;
    logic [FREE_W-1:0] free_bytes;

    modport source (output valid, ok, width, height, block_offset, read_byte,
                    free_bytes, input ready);
    modport sink (input valid, ok, width, height, block_offset, read_byte,
                  free_bytes, output ready);
endinterface

### hdl/compacting_block_pool.sv
// States per item: clear, pixel, get and unknown kinds pass EXEC and FINISH; a refused put,
// delete or read and a read past the pool end also pass CHECK; a pool read adds RD_WAIT and
// a put into a free slot adds APPEND. Put over a used slot and delete also move n = fill - block
// end bytes in MOVE and then sweep the slot table in SWEEP.
// One item is in flight at a time; the next is taken the cycle after its result is accepted.
// Reset clears the slot flags and the fill level; pool contents are undefined until written.
// ----------------------------------------------------------------------------
// compacting_block_pool
// Slot table over a packed byte pool with compaction on release.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module compacting_block_pool import cbp_pkg::*; #(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int POOL_BYTES = POOL_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cbp_req_if.sink               req,
    cbp_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(POOL_BYTES);
    localparam int FW = $clog2(POOL_BYTES + 1);
    localparam int LW = ((FW > IDX_W) ? FW : IDX_W) + 1;
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = 2 * DIM_W + AW;
    localparam logic [SW:0] SLOT_LIM = (SW + 1)'(SLOT_COUNT);
    localparam logic [LW-1:0] POOL_LIM = LW'(POOL_BYTES);

    state_t state_reg, state_next;

    // Control registers.
    logic [SLOT_COUNT-1:0] in_use_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         wp_reg;
    logic [IDX_W-1:0]      pending_reg;
    logic [DIM_W-1:0]      min_dim_reg, max_dim_reg;
    logic                  out_valid_reg;
    logic [FW-1:0]         rp_reg, dst_reg;
    logic                  mv_v_reg;
    logic [SW:0]           sw_idx_reg;
    logic                  sw_v_reg;
    logic [SW-1:0]         sw_q_reg;

    // Item and working payload.
    logic [KIND_W-1:0] kind_reg;
    logic [7:0]        slot_reg;
    logic [DIM_W-1:0]  pw_reg, ph_reg;
    logic [7:0]        px_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  osize_reg, nsize_reg;
    logic [AW-1:0]     rel_start_reg;
    logic              res_ok_reg;
    logic [DIM_W-1:0]  res_w_reg, res_h_reg;
    logic [OFF_W-1:0]  res_off_reg;
    logic [7:0]        res_byte_reg;
    logic              out_ok_reg;
    logic [DIM_W-1:0]  out_w_reg, out_h_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [7:0]        out_byte_reg;
    logic [FREE_W-1:0] out_free_reg;

    // Memory ports.
    logic          pool_we, pool_re;
    logic [AW-1:0] pool_waddr, pool_raddr;
    logic [7:0]    pool_wdata, pool_rdata;
    logic          slot_we, slot_re;
    logic [SW-1:0] slot_waddr, slot_raddr;
    logic [EW-1:0] slot_wdata, slot_rdata;

    logic          acc;
    logic          slot_ok, used, put_ok, read_ok, rd_in;
    logic [SW-1:0] sidx;
    logic [DIM_W-1:0] sq_w, sq_h;
    logic [AW-1:0] sq_start;
    logic [LW-1:0] fit_sum, mv_end, rd_sum;
    logic          fit, mv_cond, mv_rd, mv_done, sw_issue, sw_done, sw_hit;

    cbp_ram #(.DEPTH(POOL_BYTES), .WIDTH(8)) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    cbp_ram #(.DEPTH(SLOT_COUNT), .WIDTH(EW)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Handshake and decode of the latched item.
    assign req.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign acc       = req.valid && req.ready;
    assign slot_ok   = {1'b0, slot_reg} < 9'(SLOT_COUNT);
    assign sidx      = slot_reg[SW-1:0];
    assign used      = slot_ok && in_use_reg[sidx];
    assign put_ok    = (slot_reg != 8'd0) && slot_ok && dim_ok(pw_reg, min_dim_reg, max_dim_reg)
                       && dim_ok(ph_reg, min_dim_reg, max_dim_reg);
    assign sq_w      = slot_rdata[EW-1 -: DIM_W];
    assign sq_h      = slot_rdata[AW +: DIM_W];
    assign sq_start  = slot_rdata[AW-1:0];

    // Address arithmetic.
    assign fit_sum = LW'(fill_reg) + LW'(nsize_reg);
    assign fit     = fit_sum <= POOL_LIM;
    assign mv_end  = LW'(rel_start_reg) + LW'(osize_reg);
    assign mv_cond = (mv_end <= LW'(fill_reg)) && (LW'(fill_reg) <= POOL_LIM);
    assign rd_sum  = LW'(rel_start_reg) + LW'(idx_reg);
    assign read_ok = used && (idx_reg < osize_reg);
    assign rd_in   = rd_sum < POOL_LIM;

    // Compaction and sweep progress.
    assign mv_rd    = rp_reg < fill_reg;
    assign mv_done  = !mv_rd && !mv_v_reg;
    assign sw_issue = sw_idx_reg < SLOT_LIM;
    assign sw_done  = !sw_issue && !sw_v_reg;
    assign sw_hit   = sw_v_reg && in_use_reg[sw_q_reg] && (sq_start > rel_start_reg);

    // Next state and memory controls.
    always_comb
    begin
        state_next = state_reg;
        pool_we    = 1'b0;
        pool_waddr = dst_reg[AW-1:0];
        pool_wdata = pool_rdata;
        pool_re    = 1'b0;
        pool_raddr = rp_reg[AW-1:0];
        slot_we    = 1'b0;
        slot_waddr = sw_q_reg;
        slot_wdata = {sq_w, sq_h,
                      (sq_start >= AW'(osize_reg)) ? sq_start - AW'(osize_reg) : '0};
        slot_re    = 1'b0;
        slot_raddr = req.slot[SW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_re = acc;
                if (acc)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg) inside
                    KIND_PUT, KIND_READ, KIND_DELETE: state_next = ST_CHECK;
                    default:                          state_next = ST_FINISH;
                endcase
                if (kind_reg == KIND_PIXEL && pending_reg != '0
                    && wp_reg < FW'(POOL_BYTES))
                begin
                    pool_we    = 1'b1;
                    pool_waddr = wp_reg[AW-1:0];
                    pool_wdata = px_reg;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FINISH;
                case (kind_reg)
                    KIND_READ:
                    begin
                        if (read_ok && rd_in)
                        begin
                            pool_re    = 1'b1;
                            pool_raddr = rd_sum[AW-1:0];
                            state_next = ST_RD_WAIT;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (used)
                        begin
                            state_next = ST_MOVE;
                        end
                    end
                    KIND_PUT:
                    begin
                        if (put_ok)
                        begin
                            state_next = used ? ST_MOVE : ST_APPEND;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_MOVE:
            begin
                pool_re = mv_rd;
                pool_we = mv_v_reg;
                if (mv_done)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                slot_re    = sw_issue;
                slot_raddr = sw_idx_reg[SW-1:0];
                slot_we    = sw_hit;
                if (sw_done)
                begin
                    state_next = (kind_reg == KIND_PUT) ? ST_APPEND : ST_FINISH;
                end
            end
            ST_APPEND:
            begin
                slot_we    = fit;
                slot_waddr = sidx;
                slot_wdata = {pw_reg, ph_reg, fill_reg[AW-1:0]};
                state_next = ST_FINISH;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control state: slot flags, fill, pending fill, walk counters, config.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            fill_reg      <= '0;
            wp_reg        <= '0;
            pending_reg   <= '0;
            min_dim_reg   <= MIN_DIM_RST;
            max_dim_reg   <= MAX_DIM_RST;
            out_valid_reg <= 1'b0;
            rp_reg        <= '0;
            dst_reg       <= '0;
            mv_v_reg      <= 1'b0;
            sw_idx_reg    <= '0;
            sw_v_reg      <= 1'b0;
            sw_q_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MIN_DIM: min_dim_reg <= cfg_data;
                    REG_MAX_DIM: max_dim_reg <= cfg_data;
                    default:     min_dim_reg <= min_dim_reg;
                endcase
            end
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_EXEC:
                begin
                    if (kind_reg == KIND_CLEAR)
                    begin
                        in_use_reg  <= '0;
                        fill_reg    <= '0;
                        pending_reg <= '0;
                    end
                    else if (kind_reg == KIND_PIXEL && pending_reg != '0)
                    begin
                        wp_reg      <= wp_reg + 1'b1;
                        pending_reg <= pending_reg - 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    // Release setup: drop the slot and aim the byte mover.
                    if ((kind_reg == KIND_DELETE && used) || (kind_reg == KIND_PUT && put_ok))
                    begin
                        pending_reg <= '0;
                    end
                    if (used && (kind_reg == KIND_DELETE || (kind_reg == KIND_PUT && put_ok)))
                    begin
                        in_use_reg[sidx] <= 1'b0;
                        rp_reg   <= mv_cond ? mv_end[FW-1:0] : fill_reg;
                        dst_reg  <= FW'(rel_start_reg);
                        mv_v_reg <= 1'b0;
                    end
                end
                ST_MOVE:
                begin
                    if (mv_rd)
                    begin
                        rp_reg <= rp_reg + 1'b1;
                    end
                    mv_v_reg <= mv_rd;
                    if (mv_v_reg)
                    begin
                        dst_reg <= dst_reg + 1'b1;
                    end
                    if (mv_done)
                    begin
                        fill_reg   <= (fill_reg >= FW'(osize_reg)) ?
                                      fill_reg - FW'(osize_reg) : '0;
                        sw_idx_reg <= '0;
                        sw_v_reg   <= 1'b0;
                    end
                end
                ST_SWEEP:
                begin
                    if (sw_issue)
                    begin
                        sw_idx_reg <= sw_idx_reg + 1'b1;
                    end
                    sw_v_reg <= sw_issue;
                    sw_q_reg <= sw_idx_reg[SW-1:0];
                end
                ST_APPEND:
                begin
                    if (fit)
                    begin
                        in_use_reg[sidx] <= 1'b1;
                        wp_reg           <= fill_reg;
                        pending_reg      <= nsize_reg;
                        fill_reg         <= fit_sum[FW-1:0];
                    end
                end
                ST_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    wp_reg <= wp_reg;
                end
            endcase
        end
    end

    // Item fields, sizes and result payload.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    kind_reg     <= req.kind;
                    slot_reg     <= req.slot;
                    pw_reg       <= req.put_width;
                    ph_reg       <= req.put_height;
                    px_reg       <= req.pixel_value;
                    idx_reg      <= req.byte_index;
                    res_ok_reg   <= 1'b0;
                    res_w_reg    <= '0;
                    res_h_reg    <= '0;
                    res_off_reg  <= '0;
                    res_byte_reg <= '0;
                end
            end
            ST_EXEC:
            begin
                osize_reg     <= sq_w * sq_h;
                nsize_reg     <= pw_reg * ph_reg;
                rel_start_reg <= sq_start;
                if (kind_reg == KIND_CLEAR)
                begin
                    res_ok_reg <= 1'b1;
                end
                else if (kind_reg == KIND_PIXEL)
                begin
                    res_ok_reg <= (pending_reg != '0);
                end
                else if (kind_reg == KIND_GET && used)
                begin
                    res_ok_reg  <= 1'b1;
                    res_w_reg   <= sq_w;
                    res_h_reg   <= sq_h;
                    res_off_reg <= OFF_W'(sq_start);
                end
            end
            ST_CHECK:
            begin
                // A read past the pool end succeeds with a zero byte.
                if (kind_reg == KIND_READ && read_ok && !rd_in)
                begin
                    res_ok_reg <= 1'b1;
                end
            end
            ST_SWEEP:
            begin
                if (sw_done && kind_reg == KIND_DELETE)
                begin
                    res_ok_reg <= 1'b1;
                end
            end
            ST_APPEND:
            begin
                res_ok_reg <= fit;
            end
            ST_RD_WAIT:
            begin
                res_ok_reg   <= 1'b1;
                res_byte_reg <= pool_rdata;
            end
            ST_FINISH:
            begin
                out_ok_reg   <= res_ok_reg;
                out_w_reg    <= res_w_reg;
                out_h_reg    <= res_h_reg;
                out_off_reg  <= res_off_reg;
                out_byte_reg <= res_byte_reg;
                out_free_reg <= FREE_W'(POOL_LIM - LW'(fill_reg));
            end
            default:
            begin
                res_ok_reg <= res_ok_reg;
            end
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.width        = out_w_reg;
    assign rsp.height       = out_h_reg;
    assign rsp.block_offset = out_off_reg;
    assign rsp.read_byte    = out_byte_reg;
    assign rsp.free_bytes   = out_free_reg;

    // The pool never holds more than its size.
    `CBP_ASSERT(a_fill_bound, clk, rst_n, LW'(fill_reg) <= POOL_LIM)
    // A pending fill always stays inside the allocated part of the pool.
    `CBP_ASSERT(a_pending_inside, clk, rst_n,
        pending_reg != '0 |-> (LW'(wp_reg) + LW'(pending_reg)) <= LW'(fill_reg))
    // A result appears only after the finishing step.
    `CBP_ASSERT(a_rsp_from_finish, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
    // No item is taken while another is being worked on.
    `CBP_ASSERT_ALWAYS(a_no_overlap, clk, state_reg != ST_IDLE |-> !req.ready)

endmodule

### hdl/cbp_ram.sv
// ----------------------------------------------------------------------------
// cbp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbp_ram import cbp_pkg::*; #(
    parameter int DEPTH = POOL_BYTES_DEF,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered; data holds between reads.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
